### rtl/srs_pkg.sv
// ============================================================================
// srs_pkg
// Shared types and codes for the shift register stack.
// ============================================================================
package srs_pkg;

    // Default number of stack slots
    localparam int unsigned DEPTH_DEFAULT = 4;

    // Operation codes carried in an input item (code 3 is a no-op)
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
        logic [2:0]         fill_count;
    } t_out_item;

    // Controller states: output register empty or holding a result
    typedef enum logic {
        CS_EMPTY = 1'b0,
        CS_HELD  = 1'b1
    } t_ctrl_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;   // load the output register
        logic    push;      // shift down and write the pushed word
        logic    pop;       // shift up
        logic    read_top;  // report slot 0 as the result word
        t_status status;    // status code of the result
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

### rtl/srs_ctrl.sv
// ============================================================================
// srs_ctrl
// Handshake controller: decodes the operation against the stack status and
// issues datapath commands; tracks whether a result is held.
// ============================================================================
module srs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    input  logic              i_out_stall,
    input  srs_pkg::t_dp_stat i_dp_stat,
    output srs_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    srs_pkg::t_ctrl_state r_state;
    srs_pkg::t_ctrl_state n_state;
    logic                 accept;

    // Accept while the output register is free or being emptied this cycle
    assign o_in_stall  = (r_state == srs_pkg::CS_HELD) && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == srs_pkg::CS_HELD);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srs_pkg::CS_EMPTY: begin
                if (accept) n_state = srs_pkg::CS_HELD;
            end
            srs_pkg::CS_HELD: begin
                if (!i_out_stall && !accept) n_state = srs_pkg::CS_EMPTY;
            end
            default: n_state = srs_pkg::CS_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srs_pkg::CS_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.status   = srs_pkg::STAT_OK;
        case (i_operation)
            srs_pkg::OP_PUSH: begin
                if (i_dp_stat.full) begin
                    o_cmd.status = srs_pkg::STAT_OVERFLOW;
                end else begin
                    o_cmd.push = accept;
                end
            end
            srs_pkg::OP_POP: begin
                if (i_dp_stat.empty) begin
                    o_cmd.status = srs_pkg::STAT_UNDERFLOW;
                end else begin
                    o_cmd.pop      = accept;
                    o_cmd.read_top = 1'b1;
                end
            end
            srs_pkg::OP_PEEK: begin
                if (i_dp_stat.empty) begin
                    o_cmd.status = srs_pkg::STAT_UNDERFLOW;
                end else begin
                    o_cmd.read_top = 1'b1;
                end
            end
            default: begin
                // unused code: no-op
            end
        endcase
    end

endmodule

### rtl/srs_datapath.sv
// ============================================================================
// srs_datapath
// Stack slots as a shift register, fill count and output register.
// ============================================================================
module srs_datapath #(
    parameter int unsigned DEPTH = srs_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srs_pkg::t_dp_cmd   i_cmd,
    input  logic signed [31:0] i_push_value,
    output srs_pkg::t_dp_stat  o_dp_stat,
    output srs_pkg::t_out_item o_out_item
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_entries [DEPTH];
    logic signed [31:0] n_entries [DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    srs_pkg::t_out_item r_out;

    assign o_dp_stat.empty = (r_count == '0);
    assign o_dp_stat.full  = (r_count >= CW'(DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // One slot each: push takes from above, pop from below
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        always_comb begin
            n_entries[g] = r_entries[g];
            if (i_cmd.push) begin
                if (g == 0) begin
                    n_entries[g] = i_push_value;
                end else begin
                    n_entries[g] = r_entries[(g == 0) ? 0 : g - 1];
                end
            end else if (i_cmd.pop) begin
                if (g == DEPTH - 1) begin
                    n_entries[g] = '0;
                end else begin
                    n_entries[g] = r_entries[(g == DEPTH - 1) ? g : g + 1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_entries[g] <= n_entries[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out.top_value  <= i_cmd.read_top ? r_entries[0] : 32'sd0;
            r_out.status     <= i_cmd.status;
            r_out.fill_count <= 3'(n_count);
        end
    end

    assign o_out_item = r_out;

endmodule

### rtl/shift_register_stack.sv
// ============================================================================
// Shift register stack
// Bounded LIFO stack whose top always sits in slot 0, with push, pop and peek.
// ============================================================================
// An accepted item's result sits in the output register in the cycle after it is taken.
// Throughput: one item per cycle unless the sink stalls; every slot shifts in parallel.
// The next item is taken while a result waits, as long as the sink is not stalling.
// Reset (synchronous, active low) empties the stack and the output register.
// Stack slots are not cleared; only slots below the fill count are ever read.
module shift_register_stack #(
    parameter int unsigned DEPTH = srs_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srs_pkg::t_out_item o_out_item
);

    // Command and status between controller and datapath
    srs_pkg::t_dp_cmd  s_cmd;
    srs_pkg::t_dp_stat s_dp_stat;

    // Controller: decode the operation, hold the handshake state
    srs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .i_out_stall (i_out_stall),
        .i_dp_stat   (s_dp_stat),
        .o_cmd       (s_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath: shift the slots, advance the count, register the result
    srs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_push_value (i_in_item.push_value),
        .o_dp_stat    (s_dp_stat),
        .o_out_item   (o_out_item)
    );

`ifndef SYNTHESIS
    // An accepted item always leaves a result behind it
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    // A push onto a stack that is not full reports success
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.operation == srs_pkg::OP_PUSH
         && !s_dp_stat.full)
        |=> (o_out_item.status == srs_pkg::STAT_OK))
        else $error("push on non-full stack did not report ok");

    // Error results carry a zero word
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != srs_pkg::STAT_OK)
        |-> (o_out_item.top_value == 32'sd0))
        else $error("error result carries a non-zero word");

    // Full and empty are never reported together
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_dp_stat.full && s_dp_stat.empty))
        else $error("stack both full and empty");
`endif

endmodule
